/* rtl/core/fmpacl_pkg.sv */
// Package: shared types, constants and field layouts for the prefix ACL engine.
package fmpacl_pkg;

    localparam int MaxRules   = 64;
    localparam int MaxGroups  = 8;
    localparam int RuleIdxW   = $clog2(MaxRules);
    localparam int RuleCntW   = $clog2(MaxRules + 1);
    localparam int GroupW     = 3;
    localparam int V4Bits     = 32;
    localparam int V6Bits     = 128;
    localparam int LevelLimit = 8 + MaxGroups;
    localparam int LevelW     = $clog2(LevelLimit + 2);

    // request codes
    localparam logic [2:0] OpAddNet   = 3'd0;
    localparam logic [2:0] OpAddReq   = 3'd1;
    localparam logic [2:0] OpSetPar   = 3'd2;
    localparam logic [2:0] OpChkCli   = 3'd3;
    localparam logic [2:0] OpChkReq   = 3'd4;

    // status codes
    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StFull     = 3'd1;
    localparam logic [2:0] StNoParent = 3'd2;
    localparam logic [2:0] StLoop     = 3'd3;
    localparam logic [2:0] StGlobal   = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  group_id;
        logic        allow_flag;
        logic        is_ipv6;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  prefix_len;
        logic [7:0]  cmd_type;
        logic        cmd_all;
        logic [2:0]  parent_group;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic       allowed;
        logic       rule_hit;
        logic [5:0] hit_index;
    } t_out_word;

    // rule metadata as stored
    typedef struct packed {
        logic [2:0] group;
        logic       kind;
        logic       all_cmd;
        logic [7:0] cmd;
        logic [7:0] prefix;
        logic       v6;
        logic       allow;
    } t_meta;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        t_meta       meta;
    } t_rule;

    // top n bits of a 64-bit word as a mask, n in 0..64
    function automatic logic [63:0] top_mask(input logic [6:0] n);
        logic [63:0] m;
        m = '0;
        for (int k = 0; k < 64; k++) begin
            if (7'(k) < n) m[63 - k] = 1'b1;
        end
        return m;
    endfunction

endpackage

/* rtl/core/fmpacl_match.sv */
// Rule compare unit: one registered table entry against the check word.
module fmpacl_match (
    input  fmpacl_pkg::t_rule i_rule,
    input  logic              i_kind,
    input  logic [2:0]        i_group,
    input  logic              i_v6,
    input  logic [63:0]       i_hi,
    input  logic [63:0]       i_lo,
    input  logic [7:0]        i_cmd,
    output logic              o_sel,
    output logic              o_hit
);
    logic [7:0]  bits;
    logic [63:0] m_hi;
    logic [63:0] m_lo;
    logic        eq_hi;
    logic        eq_lo;
    logic        addr_ok;
    logic        cmd_ok;

    // masks for the two address halves
    always_comb begin
        bits  = i_rule.meta.prefix;
        m_hi  = fmpacl_pkg::top_mask((bits >= 8'd64) ? 7'd64 : bits[6:0]);
        m_lo  = fmpacl_pkg::top_mask((bits > 8'd64) ? 7'(bits - 8'd64) : 7'd0);
        eq_hi = ((i_hi ^ i_rule.hi) & m_hi) == '0;
        eq_lo = ((i_lo ^ i_rule.lo) & m_lo) == '0;
        if (bits == 8'd0) begin
            addr_ok = 1'b1;
        end else if (i_rule.meta.v6 != i_v6) begin
            addr_ok = 1'b0;
        end else if (!i_v6) begin
            addr_ok = (bits <= 8'(fmpacl_pkg::V4Bits)) && eq_hi;
        end else begin
            addr_ok = (bits <= 8'(fmpacl_pkg::V6Bits)) && eq_hi && eq_lo;
        end
        cmd_ok = !i_kind || i_rule.meta.all_cmd || (i_rule.meta.cmd == i_cmd);
        o_sel  = (i_rule.meta.kind == i_kind) && (i_rule.meta.group == i_group);
        o_hit  = o_sel && cmd_ok && addr_ok;
    end
endmodule

/* rtl/core/first_match_prefix_acl.sv */
// Top level: rule table, group tree and scan sequencer of the prefix ACL engine.
// An add writes one table entry unless the table is full; set parent walks the
// parent chain link by link; a check reads the table entries in turn for each
// parent-chain level visited, via the single table read port and compare unit.
// Result sits in an output register; a new word is taken once it is delivered.
// Synchronous active-low reset clears rule count, group tree and control.
module first_match_prefix_acl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  fmpacl_pkg::t_in_word  i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output fmpacl_pkg::t_out_word o_data
);
    localparam int IW = fmpacl_pkg::RuleIdxW;
    localparam int CW = fmpacl_pkg::RuleCntW;
    localparam int LW = fmpacl_pkg::LevelW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEC  = 5'b00010,
        S_LOOP = 5'b00100,
        S_SCAN = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    fmpacl_pkg::t_in_word  r_req;
    fmpacl_pkg::t_out_word r_out, n_out;
    fmpacl_pkg::t_rule     r_mem [fmpacl_pkg::MaxRules];
    fmpacl_pkg::t_rule     r_rd;
    logic [CW-1:0]         r_count;
    logic [2:0]            r_parent [fmpacl_pkg::MaxGroups];
    logic [fmpacl_pkg::MaxGroups-1:0] r_exists;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_rd_ok, n_rd_ok;
    logic [2:0]            r_grp, n_grp;
    logic [2:0]            r_walk, n_walk;
    logic [LW-1:0]         r_lvl, n_lvl;
    logic                  r_any, n_any;
    logic                  wr_en;
    logic                  sel, hit;
    logic                  kind;
    logic [7:0]            plen;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;
    assign kind    = (r_req.req_type == fmpacl_pkg::OpChkReq);

    fmpacl_match u_match (
        .i_rule(r_rd), .i_kind(kind), .i_group(r_grp), .i_v6(r_req.is_ipv6),
        .i_hi(r_req.addr_hi), .i_lo(r_req.addr_lo), .i_cmd(r_req.cmd_type),
        .o_sel(sel), .o_hit(hit)
    );

    // clamped prefix for adds
    always_comb begin
        if (r_req.is_ipv6) begin
            plen = (r_req.prefix_len > 8'(fmpacl_pkg::V6Bits)) ?
                   8'(fmpacl_pkg::V6Bits) : r_req.prefix_len;
        end else begin
            plen = (r_req.prefix_len > 8'(fmpacl_pkg::V4Bits)) ?
                   8'(fmpacl_pkg::V4Bits) : r_req.prefix_len;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        n_idx   = r_idx;
        n_rd_ok = 1'b0;
        n_grp   = r_grp;
        n_walk  = r_walk;
        n_lvl   = r_lvl;
        n_any   = r_any;
        wr_en   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DEC;
            end
            S_DEC: begin
                n_out   = '0;
                n_state = S_OUT;
                n_idx   = '0;
                n_any   = 1'b0;
                n_lvl   = '0;
                priority if (r_req.req_type == fmpacl_pkg::OpAddNet ||
                             r_req.req_type == fmpacl_pkg::OpAddReq) begin
                    if (r_count >= CW'(fmpacl_pkg::MaxRules)) begin
                        n_out.status = fmpacl_pkg::StFull;
                    end else begin
                        wr_en = 1'b1;
                    end
                end else if (r_req.req_type == fmpacl_pkg::OpSetPar) begin
                    if (r_req.group_id == 3'd0) begin
                        n_out.status = fmpacl_pkg::StGlobal;
                    end else if (!r_exists[r_req.parent_group]) begin
                        n_out.status = fmpacl_pkg::StNoParent;
                    end else begin
                        n_walk  = r_req.parent_group;
                        n_state = S_LOOP;
                    end
                end else if (r_req.req_type == fmpacl_pkg::OpChkCli ||
                             r_req.req_type == fmpacl_pkg::OpChkReq) begin
                    n_grp   = r_exists[r_req.group_id] ? r_req.group_id : 3'd0;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_LOOP: begin
                // walk the parent chain one link a cycle
                if (r_walk == r_req.group_id) begin
                    n_out.status = fmpacl_pkg::StLoop;
                    n_state      = S_OUT;
                end else if (r_walk == 3'd0) begin
                    n_state = S_OUT;
                end else begin
                    n_walk = r_parent[r_walk];
                end
            end
            S_SCAN: begin
                // r_rd holds entry r_idx-1 when r_rd_ok is set
                if (r_rd_ok && sel) n_any = 1'b1;
                if (r_rd_ok && hit) begin
                    n_out.allowed   = r_rd.meta.allow;
                    n_out.rule_hit  = 1'b1;
                    n_out.hit_index = 6'(r_idx - CW'(1));
                    n_state         = S_OUT;
                end else if (r_idx == r_count && (r_rd_ok || r_count == '0)) begin
                    // end of this level
                    n_idx = '0;
                    if (!(r_any || (r_rd_ok && sel))) begin
                        n_out.allowed = 1'b1;
                        n_state       = S_OUT;
                    end else if (r_grp == 3'd0 ||
                                 r_lvl == LW'(fmpacl_pkg::LevelLimit)) begin
                        n_state = S_OUT;
                    end else begin
                        n_grp = r_parent[r_grp];
                        n_lvl = r_lvl + LW'(1);
                        n_any = 1'b0;
                    end
                end else begin
                    n_rd_ok = 1'b1;
                    n_idx   = r_idx + CW'(1);
                end
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_exists <= fmpacl_pkg::MaxGroups'(1);
            r_rd_ok  <= 1'b0;
            for (int g = 0; g < fmpacl_pkg::MaxGroups; g++) r_parent[g] <= 3'd0;
        end else begin
            r_state <= n_state;
            r_rd_ok <= n_rd_ok;
            if (r_state == S_DEC &&
                (r_req.req_type == fmpacl_pkg::OpAddNet ||
                 r_req.req_type == fmpacl_pkg::OpAddReq ||
                 (r_req.req_type == fmpacl_pkg::OpSetPar && r_req.group_id != 3'd0 &&
                  r_exists[r_req.parent_group])) &&
                !r_exists[r_req.group_id]) begin
                r_exists[r_req.group_id] <= 1'b1;
                r_parent[r_req.group_id] <= 3'd0;
            end
            if (wr_en) r_count <= r_count + CW'(1);
            if (r_state == S_LOOP && n_state == S_OUT && r_walk != r_req.group_id)
                r_parent[r_req.group_id] <= r_req.parent_group;
        end
    end

    // payload registers and table port
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) r_req <= i_data;
        r_out  <= n_out;
        r_idx  <= n_idx;
        r_grp  <= n_grp;
        r_walk <= n_walk;
        r_lvl  <= n_lvl;
        r_any  <= n_any;
        if (wr_en) begin
            r_mem[r_count[IW-1:0]] <= '{hi: r_req.addr_hi, lo: r_req.addr_lo,
                meta: '{group: r_req.group_id, kind: r_req.req_type[0],
                        all_cmd: r_req.req_type[0] & r_req.cmd_all,
                        cmd: r_req.req_type[0] ? r_req.cmd_type : 8'd0,
                        prefix: plen, v6: r_req.is_ipv6, allow: r_req.allow_flag}};
        end
        r_rd <= r_mem[r_idx[IW-1:0]];
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(fmpacl_pkg::MaxRules))
        else $error("rule count overflow");
    a_global: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exists[0] && r_parent[0] == 3'd0)
        else $error("global group altered");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result dropped while stalled");
    a_check_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.rule_hit |-> o_data.status == fmpacl_pkg::StOk)
        else $error("hit with nonzero status");
endmodule
